/* rtl/core/fling_remaining_distance_estimator_core_defines.svh */
// Assertion macros for the fling remaining-distance estimator checker.
// No dependencies; included by frde_checker.sv.
`ifndef FLING_REMAINING_DISTANCE_ESTIMATOR_CORE_DEFINES_SVH
`define FLING_REMAINING_DISTANCE_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/frde_pkg.sv */
// Shared types and constants of the fling remaining-distance estimator.
// No dependencies; imported by the controller, the datapath and the top level.
package frde_pkg;

  localparam int OUT_W       = 28;
  localparam int SHARE_W     = 16;
  localparam int DEN_W       = 17;
  localparam int RUN_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int OUT_POS_MAX = 134217727;
  localparam int OUT_NEG_MAG = 134217728;
  localparam int SHARE_ONE   = 65536;

  localparam logic [SHARE_W-1:0] THR_RESET  = 16'd62915;
  localparam logic [SHARE_W-1:0] CAP_RESET  = 16'd64881;
  localparam logic [RUN_W-1:0]   NEED_RESET = 4'd3;
  localparam logic [RUN_W-1:0]   RUN_MAX    = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_THR   = 2'd0,
    CFG_SLOW_CAP    = 2'd1,
    CFG_SHRINK_NEED = 2'd2
  } cfg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SQ_A   = 9'b000000010,
    ST_SQ_B   = 9'b000000100,
    ST_ROOT   = 9'b000001000,
    ST_CHECK  = 9'b000010000,
    ST_DIV    = 9'b000100000,
    ST_DECIDE = 9'b001000000,
    ST_LOADY  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    PH_SHARE = 2'd0,
    PH_X     = 2'd1,
    PH_Y     = 2'd2
  } div_phase_t;

  typedef struct packed {
    logic load;
    logic sel_prev;
    logic sq_a;
    logic sq_b;
    logic root_step;
    logic div_load_share;
    logic div_step;
    logic decide;
    logic div_load_y;
    logic out_write;
    logic out_est;
  } cmd_t;

  typedef struct packed {
    logic had_prior;
    logic prev_zero;
    logic decaying;
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/fling_remaining_distance_estimator_core.sv */
// Fling remaining-distance estimator, top level. Uses frde_pkg, frde_ctrl, frde_datapath.
// A restart or a first delta goes from idle straight to the output state, which writes the
// output register once it is free; a full estimate runs two square roots of DELTA_BITS
// steps each and up to three passes of a (DELTA_BITS+18)-step divider. Only one
// transaction is taken at a time: in_ready is high only in the idle state.
// Reset (rst, synchronous, active high) clears history, run count, out_valid; restores config.
module fling_remaining_distance_estimator_core #(
  parameter int DELTA_BITS = 21
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [frde_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frde_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [DELTA_BITS-1:0]       delta_x,
  input  logic signed [DELTA_BITS-1:0]       delta_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               estimate_valid,
  output logic signed [frde_pkg::OUT_W-1:0]  remaining_x,
  output logic signed [frde_pkg::OUT_W-1:0]  remaining_y
);
  import frde_pkg::*;

  // The controller walks each estimate through its steps: square both
  // components of the new delta, take the root, do the same for the previous
  // delta, then, unless that root is zero, divide for the decay share. If
  // momentum is decaying, the same divider runs twice more to scale the two
  // components. The datapath holds every register that carries numbers,
  // including the history and the output register, and reports status flags.
  cmd_t  cmd;
  stat_t stat;

  frde_ctrl #(
    .DELTA_BITS(DELTA_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The output register lets a finished result wait for the consumer while
  // the controller returns to idle once it has been written.
  frde_datapath #(
    .DELTA_BITS(DELTA_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .delta_x        (delta_x),
    .delta_y        (delta_y),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .estimate_valid (estimate_valid),
    .remaining_x    (remaining_x),
    .remaining_y    (remaining_y)
  );

endmodule

/* rtl/core/frde_ctrl.sv */
// Sequencing controller of the fling remaining-distance estimator.
// Depends on frde_pkg; drives the datapath through frde_pkg::cmd_t.
module frde_ctrl #(
  parameter int DELTA_BITS = 21
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           op,
  input  frde_pkg::stat_t stat,
  output frde_pkg::cmd_t  cmd
);
  import frde_pkg::*;

  localparam int NW = DELTA_BITS + 18;
  localparam int CW = $clog2(NW);

  state_t     state, state_next;
  div_phase_t phase, phase_next;
  logic       sel_prev, sel_prev_next;
  logic       est, est_next;
  logic [CW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_SHARE;
      sel_prev <= 1'b0;
      est      <= 1'b0;
      cnt      <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      sel_prev <= sel_prev_next;
      est      <= est_next;
      cnt      <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    sel_prev_next = sel_prev;
    est_next      = est;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.sel_prev  = sel_prev;
    cmd.out_est   = est;
    in_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (op || !stat.had_prior) begin
            est_next   = 1'b0;
            state_next = ST_OUT;
          end else begin
            sel_prev_next = 1'b0;
            state_next    = ST_SQ_A;
          end
        end
      end
      ST_SQ_A: begin
        cmd.sq_a   = 1'b1;
        state_next = ST_SQ_B;
      end
      ST_SQ_B: begin
        cmd.sq_b   = 1'b1;
        cnt_next   = '0;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == CW'(DELTA_BITS - 1)) begin
          if (!sel_prev) begin
            sel_prev_next = 1'b1;
            state_next    = ST_SQ_A;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat.prev_zero) begin
          est_next   = 1'b0;
          state_next = ST_OUT;
        end else begin
          cmd.div_load_share = 1'b1;
          phase_next         = PH_SHARE;
          cnt_next           = '0;
          state_next         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          unique case (phase)
            PH_SHARE: state_next = ST_DECIDE;
            PH_X:     state_next = ST_LOADY;
            PH_Y: begin
              est_next   = 1'b1;
              state_next = ST_OUT;
            end
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_next   = '0;
        if (stat.decaying) begin
          phase_next = PH_X;
          state_next = ST_DIV;
        end else begin
          est_next   = 1'b0;
          state_next = ST_OUT;
        end
      end
      ST_LOADY: begin
        cmd.div_load_y = 1'b1;
        phase_next     = PH_Y;
        cnt_next       = '0;
        state_next     = ST_DIV;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_write = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/frde_datapath.sv */
// Datapath of the fling remaining-distance estimator: history, squarer,
// bit-serial square root, shared restoring divider and output register. Uses frde_pkg.
module frde_datapath #(
  parameter int DELTA_BITS = 21
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [frde_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frde_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  op,
  input  logic signed [DELTA_BITS-1:0]          delta_x,
  input  logic signed [DELTA_BITS-1:0]          delta_y,
  input  frde_pkg::cmd_t                        cmd,
  output frde_pkg::stat_t                       stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  estimate_valid,
  output logic signed [frde_pkg::OUT_W-1:0]     remaining_x,
  output logic signed [frde_pkg::OUT_W-1:0]     remaining_y
);
  import frde_pkg::*;

  localparam int D  = DELTA_BITS;
  localparam int NW = D + 18;
  localparam int RW = 2 * D;
  localparam int QW = (NW > OUT_W + 1) ? NW : OUT_W + 1;

  logic [SHARE_W-1:0] thr, cap;
  logic [RUN_W-1:0]   need, run;
  logic [D-1:0]       px, py, cx, cy, ox, oy;
  logic               present;
  logic [RW-1:0]      sq, rad;
  logic [D+1:0]       rrem;
  logic [D-1:0]       root, len;
  logic [NW-1:0]      num, divsr, qx;
  logic [NW:0]        drem;

  logic [D-1:0]       m_cx, m_cy, m_ox, m_oy, mul_op;
  logic [RW-1:0]      prod;
  logic [D+3:0]       rsh, rtrial;
  logic               rge;
  logic [NW:0]        dsh;
  logic               dge;
  logic               share_ge;
  logic [SHARE_W-1:0] share, used;
  logic [RUN_W-1:0]   run_new;
  logic [DEN_W-1:0]   den;

  function automatic logic [D-1:0] mag(input logic [D-1:0] v);
    return v[D-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [NW-1:0] q, input logic neg);
    logic [QW-1:0] qe;
    qe = QW'(q);
    if (neg) begin
      if (qe > QW'(OUT_NEG_MAG)) qe = QW'(OUT_NEG_MAG);
      return ~qe[OUT_W-1:0] + 1'b1;
    end
    if (qe > QW'(OUT_POS_MAX)) qe = QW'(OUT_POS_MAX);
    return qe[OUT_W-1:0];
  endfunction

  assign m_cx   = mag(cx);
  assign m_cy   = mag(cy);
  assign m_ox   = mag(ox);
  assign m_oy   = mag(oy);
  assign mul_op = cmd.sel_prev ? (cmd.sq_b ? m_oy : m_ox) : (cmd.sq_b ? m_cy : m_cx);
  assign prod   = RW'(mul_op) * RW'(mul_op);

  // One root digit per cycle, two radicand bits consumed per step.
  assign rsh    = {rrem, rad[RW-1 -: 2]};
  assign rtrial = {2'b00, root, 2'b01};
  assign rge    = rsh >= rtrial;

  // One quotient bit per cycle; the quotient shifts in where the dividend leaves.
  assign dsh = {drem[NW-1:0], num[NW-1]};
  assign dge = dsh >= {1'b0, divsr};

  assign share_ge = |num[NW-1:SHARE_W];
  assign share    = num[SHARE_W-1:0];
  assign run_new  = share_ge ? '0 : ((run == RUN_MAX) ? run : run + 1'b1);
  assign used     = (share < cap) ? share : cap;
  assign den      = DEN_W'(SHARE_ONE) - DEN_W'(used);

  assign stat.had_prior = present;
  assign stat.prev_zero = (root == '0);
  assign stat.decaying  = !share_ge && ((share < thr) || (run_new >= need));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= THR_RESET;
      cap     <= CAP_RESET;
      need    <= NEED_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DECAY_THR:   thr  <= cfg_data[SHARE_W-1:0];
        CFG_SLOW_CAP:    cap  <= cfg_data[SHARE_W-1:0];
        CFG_SHRINK_NEED: need <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px      <= '0;
      py      <= '0;
      present <= 1'b0;
      run     <= '0;
    end else if (cmd.load) begin
      if (op) begin
        px      <= '0;
        py      <= '0;
        present <= 1'b0;
        run     <= '0;
      end else begin
        px      <= delta_x;
        py      <= delta_y;
        present <= 1'b1;
      end
    end else if (cmd.decide) begin
      run <= run_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= delta_x;
      cy <= delta_y;
      ox <= px;
      oy <= py;
    end
    if (cmd.sq_a) begin
      sq <= prod;
      if (cmd.sel_prev) len <= root;
    end
    if (cmd.sq_b) begin
      rad  <= sq + prod;
      root <= '0;
      rrem <= '0;
    end
    if (cmd.root_step) begin
      rrem <= rge ? (D + 2)'(rsh - rtrial) : rsh[D+1:0];
      rad  <= rad << 2;
      root <= {root[D-2:0], rge};
    end
    if (cmd.div_load_share) begin
      num   <= NW'(len) << SHARE_W;
      divsr <= NW'(root);
      drem  <= '0;
    end
    if (cmd.div_step) begin
      drem <= dge ? (dsh - {1'b0, divsr}) : dsh;
      num  <= {num[NW-2:0], dge};
    end
    if (cmd.decide && stat.decaying) begin
      num   <= (NW'(m_cx) << (DEN_W)) + NW'(den);
      divsr <= NW'({den, 1'b0});
      drem  <= '0;
    end
    if (cmd.div_load_y) begin
      qx   <= num;
      num  <= (NW'(m_cy) << (DEN_W)) + NW'(divsr[DEN_W:1]);
      drem <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_write) begin
      estimate_valid <= cmd.out_est;
      remaining_x    <= cmd.out_est ? sat_out(qx, cx[D-1]) : '0;
      remaining_y    <= cmd.out_est ? sat_out(num, cy[D-1]) : '0;
    end
  end

endmodule

/* rtl/core/frde_checker.sv */
// Port-level checker for the fling remaining-distance estimator, with its bind.
// Depends on frde_pkg and fling_remaining_distance_estimator_core_defines.svh.
`include "fling_remaining_distance_estimator_core_defines.svh"

module frde_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              estimate_valid,
  input logic [frde_pkg::OUT_W-1:0]        remaining_x,
  input logic [frde_pkg::OUT_W-1:0]        remaining_y
);

  `FRDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FRDE_ASSERT_NOW(a_invalid_zero, out_valid && !estimate_valid,
    remaining_x == '0 && remaining_y == '0, "invalid result carries nonzero travel")
  `FRDE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
    "second transaction taken while one is in progress")

endmodule

bind fling_remaining_distance_estimator_core frde_checker u_frde_checker (.*);
